// ===== hdl/gspe_pkg.sv =====
// Package for the graph eccentricity engine: constants, FSM state type.
// No dependencies.
package gspe_pkg;
    localparam int DIST_BITS = 8;
    localparam logic [7:0] UNREACH = 8'hFF;
    localparam logic [7:0] DIST_MAX = 8'hFE;
    localparam int MAX_OUT = 16;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN = 1'b1;
    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_START = 1'b1;
    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_RD, S_SWEEP, S_CHECK, S_ECC, S_EMIT
    } t_state;
endpackage

// ===== hdl/gspe_if.sv =====
// Valid/ready channel interfaces for items and configuration writes.
// No dependencies.
interface gspe_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] weight;
    modport source (output valid, op, row, col, weight, input ready);
    modport sink (input valid, op, row, col, weight, output ready);
endinterface

interface gspe_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] vertex;
    logic [7:0] start_distance;
    logic [7:0] eccentricity;
    logic       is_central;
    logic       is_peripheral;
    logic [7:0] radius;
    logic [7:0] diameter;
    logic       last;
    modport source (output valid, vertex, start_distance, eccentricity, is_central,
                    is_peripheral, radius, diameter, last, input ready);
    modport sink (input valid, vertex, start_distance, eccentricity, is_central,
                  is_peripheral, radius, diameter, last, output ready);
endinterface

interface gspe_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/gspe_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module gspe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/gspe_cell.sv =====
// One vertex cell: holds a distance, relaxes it against the broadcast
// candidate, and passes its distance to the previous cell for the max chain.
// Depends on gspe_pkg.
module gspe_cell (
    input  logic       i_clk,
    input  logic       i_init,
    input  logic       i_is_src,
    input  logic       i_relax,
    input  logic [7:0] i_cand,
    input  logic       i_shift,
    input  logic [7:0] i_prev,
    output logic [7:0] o_dist,
    output logic       o_improved
);
    logic [7:0] r_dist;
    assign o_improved = i_relax && (i_cand < r_dist);
    always_ff @(posedge i_clk) begin
        if (i_init) r_dist <= i_is_src ? 8'd0 : gspe_pkg::UNREACH;
        else if (i_shift) r_dist <= i_prev;
        else if (o_improved) r_dist <= i_cand;
    end
    assign o_dist = r_dist;
endmodule

// ===== hdl/graph_shortest_path_eccentricity.sv =====
// Graph eccentricity engine: weighted matrix in RAM, row of vertex cells.
// Write item: written in the cycle it is accepted, next item accepted the cycle after.
// Run item of n vertices: per source an init step, then per pending vertex a pick, a
// read and a row sweep, a final check and a shift of the cell row out; then n results,
// held by output stalls. Re-relaxed vertices add more sweeps.
// Sync active-low reset: matrix clear of every RAM word; count 16, start 0.
module graph_shortest_path_eccentricity #(
    parameter int VERTICES = 16,
    parameter int WEIGHT_BITS = 4
) (
    input logic i_clk,
    input logic i_rst_n,
    gspe_in_if.sink    in_ch,
    gspe_cfg_if.sink   cfg_ch,
    gspe_out_if.source out_ch
);
    localparam int VB = $clog2(VERTICES);
    localparam int AB = 2 * VB;
    localparam int RAM_DEPTH = 1 << AB;
    localparam int NMAX = (VERTICES < 16) ? VERTICES : 16;

    gspe_pkg::t_state r_state, n_state;
    logic [4:0] r_vcount;
    logic [3:0] r_start;
    logic [VB:0] r_n;
    logic [AB:0] r_clr;
    logic [VB:0] r_s, r_u, r_i;
    logic [VERTICES-1:0] r_pend;
    logic [VB:0] r_k;
    logic [7:0] r_ecc [VERTICES];
    logic [7:0] r_sd [VERTICES];
    logic [7:0] r_rad, r_dia, r_du, r_e;

    logic          ram_we;
    logic [AB-1:0] ram_addr;
    logic [WEIGHT_BITS-1:0] ram_wd, ram_rd;
    logic [7:0] cell_dist [VERTICES];
    logic [VERTICES-1:0] imp;
    logic [8:0] sum;
    logic [7:0] cand;
    logic [VB-1:0] pick;
    logic in_range, clearing;

    assign clearing = !r_clr[AB];
    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready = (r_state == gspe_pkg::S_IDLE) && !clearing;
    assign in_range = ({4'd0, in_ch.row} < 8'(VERTICES)) && ({4'd0, in_ch.col} < 8'(VERTICES));

    always_comb begin
        ram_we = 1'b0;
        ram_addr = '0;
        ram_wd = WEIGHT_BITS'(in_ch.weight);
        if (clearing) begin
            ram_we = 1'b1;
            ram_addr = r_clr[AB-1:0];
            ram_wd = '0;
        end else if (r_state == gspe_pkg::S_IDLE) begin
            ram_we = in_ch.valid && in_ch.op == gspe_pkg::OP_WRITE && in_range;
            ram_addr = {VB'(in_ch.row), VB'(in_ch.col)};
        end else begin
            ram_addr = {r_u[VB-1:0], r_i[VB-1:0]};
        end
    end

    gspe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    // weight read for column r_i-1 arrives while r_i advances
    logic [VB:0] r_col_d;
    logic r_sweep_v;
    always_ff @(posedge i_clk) begin
        r_col_d <= r_i;
        r_sweep_v <= (r_state == gspe_pkg::S_RD || r_state == gspe_pkg::S_SWEEP) && (r_i < r_n);
    end
    assign sum = {1'b0, r_du} + 9'(ram_rd);
    assign cand = (sum > 9'(gspe_pkg::DIST_MAX)) ? gspe_pkg::DIST_MAX : sum[7:0];

    for (genvar g = 0; g < VERTICES; g++) begin : g_cell
        gspe_cell u_cell (
            .i_clk(i_clk),
            .i_init(r_state == gspe_pkg::S_INIT),
            .i_is_src(r_s == (VB+1)'(g)),
            .i_relax(r_sweep_v && r_col_d == (VB+1)'(g) && ram_rd != '0),
            .i_cand(cand),
            .i_shift(r_state == gspe_pkg::S_ECC),
            .i_prev(cell_dist[(g + 1) % VERTICES]),
            .o_dist(cell_dist[g]),
            .o_improved(imp[g])
        );
    end

    always_comb begin
        pick = '0;
        for (int j = VERTICES - 1; j >= 0; j--) if (r_pend[j]) pick = VB'(j);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gspe_pkg::S_IDLE:
                if (in_ch.valid && in_ch.ready && in_ch.op == gspe_pkg::OP_RUN)
                    n_state = gspe_pkg::S_INIT;
            gspe_pkg::S_INIT: n_state = gspe_pkg::S_CHECK;
            gspe_pkg::S_CHECK:
                n_state = (r_pend == '0) ? gspe_pkg::S_ECC : gspe_pkg::S_RD;
            gspe_pkg::S_RD: n_state = gspe_pkg::S_SWEEP;
            gspe_pkg::S_SWEEP:
                if (r_i == r_n + 1'b1) n_state = gspe_pkg::S_CHECK;
            gspe_pkg::S_ECC:
                if (r_i == (VB+1)'(VERTICES - 1))
                    n_state = (r_s + 1'b1 == r_n) ? gspe_pkg::S_EMIT : gspe_pkg::S_INIT;
            gspe_pkg::S_EMIT:
                if (out_ch.ready && r_k + 1'b1 == r_n) n_state = gspe_pkg::S_IDLE;
            default: n_state = gspe_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gspe_pkg::S_IDLE;
            r_vcount <= 5'd16;
            r_start <= 4'd0;
            r_clr <= '0;
            r_pend <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (cfg_ch.valid) begin
                if (cfg_ch.index == gspe_pkg::CFG_VCOUNT) r_vcount <= cfg_ch.data;
                else r_start <= cfg_ch.data[3:0];
            end
            case (r_state)
                gspe_pkg::S_INIT: r_pend <= VERTICES'(1) << r_s;
                gspe_pkg::S_CHECK: if (r_pend != '0) r_pend[pick] <= 1'b0;
                gspe_pkg::S_SWEEP: r_pend <= r_pend | imp;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gspe_pkg::S_IDLE: begin
                r_n <= (r_vcount == 5'd0) ? (VB+1)'(1) :
                       ({1'b0, r_vcount} > 6'(NMAX)) ? (VB+1)'(NMAX) : (VB+1)'(r_vcount);
                r_s <= '0;
                r_k <= '0;
                r_rad <= gspe_pkg::UNREACH;
                r_dia <= '0;
                for (int j = 0; j < VERTICES; j++) r_sd[j] <= gspe_pkg::UNREACH;
            end
            gspe_pkg::S_INIT: r_e <= '0;
            gspe_pkg::S_CHECK: begin
                r_u <= {1'b0, pick};
                r_du <= cell_dist[pick];
                r_i <= '0;
            end
            gspe_pkg::S_RD, gspe_pkg::S_SWEEP: r_i <= r_i + 1'b1;
            gspe_pkg::S_ECC: begin
                if (r_state != n_state) r_i <= '0;
                else r_i <= r_i + 1'b1;
                if (r_i < r_n && cell_dist[0] > r_e) r_e <= cell_dist[0];
                if (8'(r_s) == 8'(r_start) && r_i < r_n) r_sd[r_i[VB-1:0]] <= cell_dist[0];
                if (r_i == (VB+1)'(VERTICES - 1)) begin
                    logic [7:0] e;
                    e = (r_i < r_n && cell_dist[0] > r_e) ? cell_dist[0] : r_e;
                    r_ecc[r_s[VB-1:0]] <= e;
                    if (e < r_rad) r_rad <= e;
                    if (e > r_dia) r_dia <= e;
                    r_s <= r_s + 1'b1;
                end
            end
            gspe_pkg::S_EMIT: if (out_ch.ready) r_k <= r_k + 1'b1;
            default: ;
        endcase
        if (r_state == gspe_pkg::S_CHECK && r_pend == '0) r_i <= '0;
    end

    assign out_ch.valid = (r_state == gspe_pkg::S_EMIT);
    assign out_ch.vertex = 4'(r_k);
    assign out_ch.start_distance = r_sd[r_k[VB-1:0]];
    assign out_ch.eccentricity = r_ecc[r_k[VB-1:0]];
    assign out_ch.is_central = r_ecc[r_k[VB-1:0]] == r_rad;
    assign out_ch.is_peripheral = r_ecc[r_k[VB-1:0]] == r_dia;
    assign out_ch.radius = r_rad;
    assign out_ch.diameter = r_dia;
    assign out_ch.last = (r_k + 1'b1 == r_n);
endmodule
